FILE: hw/rtl/psci_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psci_pkg
// Shared types and codes for the power sequencer with cooling interlock.
// ----------------------------------------------------------------------------
package psci_pkg;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_TOGGLE = 2'd2,
        CMD_ACK    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PRESS_NONE  = 2'd0,
        PRESS_SHORT = 2'd1,
        PRESS_LONG  = 2'd2
    } press_t;

    typedef enum logic [2:0] {
        REG_SHORT_PRESS  = 3'd0,
        REG_LONG_PRESS   = 3'd1,
        REG_COOLDOWN     = 3'd2,
        REG_SPINUP       = 3'd3,
        REG_COOL_OFF     = 3'd4,
        REG_GRACE        = 3'd5,
        REG_START_POL    = 3'd6,
        REG_RUN_POL      = 3'd7
    } reg_idx_t;

    localparam int NUM_CHANNELS = 4;
    localparam int CFG_DATA_W  = 22;
    localparam int CFG_ADDR_W  = 3;
    localparam int CMD_W       = 2;
    localparam int CH_W        = $clog2(NUM_CHANNELS);

    localparam logic [15:0] RST_SHORT_PRESS = 16'd300;
    localparam logic [15:0] RST_LONG_PRESS  = 16'd6000;
    localparam logic [15:0] RST_COOLDOWN    = 16'd4000;
    localparam logic [21:0] RST_SPINUP      = 22'd10000;
    localparam logic [21:0] RST_COOL_OFF    = 22'd30000;
    localparam logic [21:0] RST_GRACE       = 22'd5000;

    typedef struct packed {
        logic [15:0] short_press_ms;
        logic [15:0] long_press_ms;
        logic [15:0] press_cooldown_ms;
        logic [21:0] spinup_timeout_ms;
        logic [21:0] cool_off_delay_ms;
        logic [21:0] fault_grace_ms;
        logic        start_pol_high;
        logic        run_pol_high;
    } cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/power_sequencer_cooling_interlock.sv
`default_nettype none
// ----------------------------------------------------------------------------
// power_sequencer_cooling_interlock
// Top level: input register, sequencer core, result register.
// ----------------------------------------------------------------------------
// Each request (tick, set, toggle, fault acknowledge) is captured in an input
// register, applied to the sequencer state registers, and its result is read
// from a result register. A new request is taken every cycle unless m_ready
// stalls the output; throughput is one request per clock while unstalled.
// The result reflects the state after the request. Start line polarity
// follows the configuration register at the time the result is formed.
module power_sequencer_cooling_interlock #(
    parameter int TIME_BITS    = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [psci_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [psci_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [psci_pkg::CMD_W-1:0]      s_cmd,
    input  wire logic [psci_pkg::CH_W-1:0]       s_channel,
    input  wire logic                            s_turn_on,
    input  wire logic [psci_pkg::NUM_CHANNELS-1:0] s_monitor_levels,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [psci_pkg::NUM_CHANNELS-1:0]    m_start_lines,
    output logic [psci_pkg::NUM_CHANNELS-1:0]    m_channel_on,
    output logic                                 m_cooling_fault,
    output logic                                 m_cooling_locked
);
    import psci_pkg::*;

    cfg_t cfg;
    logic in_v_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic [CH_W-1:0]  ch_reg;
    logic on_reg;
    logic [NUM_CHANNELS-1:0] mon_reg;
    logic core_done_reg;
    logic [NUM_CHANNELS-1:0] mon_hold_reg;
    logic [NUM_CHANNELS-1:0] sl, co;
    logic cf, cl;
    logic out_free, stage_adv;

    psci_cfg_regs u_cfg (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata, .cfg
    );

    // stage 1: input register; stage 2: state applied; stage 3: result reg
    assign out_free  = !m_valid || m_ready;
    assign stage_adv = !core_done_reg || out_free;
    assign s_ready   = !in_v_reg || stage_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_ready) begin
            in_v_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            cmd_reg <= s_cmd;
            ch_reg  <= s_channel;
            on_reg  <= s_turn_on;
            mon_reg <= s_monitor_levels;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core_done_reg <= 1'b0;
            mon_hold_reg  <= '0;
        end else begin
            if (stage_adv)
                core_done_reg <= in_v_reg;
            if (stage_adv && in_v_reg)
                mon_hold_reg <= mon_reg;
        end
    end

    psci_core #(.TIME_BITS(TIME_BITS)) u_core (
        .aclk, .aresetn,
        .en             (stage_adv && in_v_reg),
        .cmd            (cmd_reg),
        .channel        (ch_reg),
        .turn_on        (on_reg),
        .mon            (mon_reg),
        .mon_res        (mon_hold_reg),
        .cfg,
        .start_lines    (sl),
        .channel_on     (co),
        .cooling_fault  (cf),
        .cooling_locked (cl)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_free) begin
            m_valid <= core_done_reg;
        end
        if (out_free && core_done_reg) begin
            m_start_lines    <= sl;
            m_channel_on     <= co;
            m_cooling_fault  <= cf;
            m_cooling_locked <= cl;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_channel_on))
        else $error("result dropped while stalled");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        core_done_reg && !out_free |=> core_done_reg)
        else $error("applied request lost");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_v_reg |-> s_ready)
        else $error("input stalled while empty");

endmodule
`default_nettype wire

FILE: hw/rtl/psci_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psci_cfg_regs
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
module psci_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [psci_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [psci_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output psci_pkg::cfg_t                      cfg
);
    import psci_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_press_ms       <= RST_SHORT_PRESS;
            cfg_reg.long_press_ms        <= RST_LONG_PRESS;
            cfg_reg.press_cooldown_ms    <= RST_COOLDOWN;
            cfg_reg.spinup_timeout_ms    <= RST_SPINUP;
            cfg_reg.cool_off_delay_ms    <= RST_COOL_OFF;
            cfg_reg.fault_grace_ms       <= RST_GRACE;
            cfg_reg.start_pol_high       <= 1'b1;
            cfg_reg.run_pol_high         <= 1'b0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_SHORT_PRESS: cfg_reg.short_press_ms       <= cfg_wdata[15:0];
                REG_LONG_PRESS:  cfg_reg.long_press_ms        <= cfg_wdata[15:0];
                REG_COOLDOWN:    cfg_reg.press_cooldown_ms    <= cfg_wdata[15:0];
                REG_SPINUP:      cfg_reg.spinup_timeout_ms    <= cfg_wdata;
                REG_COOL_OFF:    cfg_reg.cool_off_delay_ms    <= cfg_wdata;
                REG_GRACE:       cfg_reg.fault_grace_ms       <= cfg_wdata;
                REG_START_POL:   cfg_reg.start_pol_high       <= cfg_wdata[0];
                REG_RUN_POL:     cfg_reg.run_pol_high         <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/psci_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psci_core
// Sequencer state and next-state logic; one request applied per enable.
// ----------------------------------------------------------------------------
module psci_core #(
    parameter int TIME_BITS    = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic [psci_pkg::CMD_W-1:0] cmd,
    input  wire logic [psci_pkg::CH_W-1:0]  channel,
    input  wire logic                     turn_on,
    input  wire logic [psci_pkg::NUM_CHANNELS-1:0] mon,
    input  wire logic [psci_pkg::NUM_CHANNELS-1:0] mon_res,
    input  wire psci_pkg::cfg_t           cfg,
    output logic [psci_pkg::NUM_CHANNELS-1:0] start_lines,
    output logic [psci_pkg::NUM_CHANNELS-1:0] channel_on,
    output logic                          cooling_fault,
    output logic                          cooling_locked
);
    import psci_pkg::*;

    localparam int NPC  = NUM_CHANNELS - 1;
    localparam int COOL = NUM_CHANNELS - 1;

    typedef logic [TIME_BITS-1:0] tm_t;

    tm_t        now_reg, now_next;
    logic       cc_reg, cc_next, ca_reg, ca_next, op_reg, op_next;
    logic       fl_reg, fl_next, gr_reg, gr_next;
    tm_t        offd_reg, offd_next, grd_reg, grd_next;
    press_t     req_reg [NPC], req_next [NPC];
    logic [NPC-1:0] prs_reg, prs_next, sw_reg, sw_next;
    tm_t        pend_reg [NPC], pend_next [NPC];
    tm_t        cdu_reg [NPC], cdu_next [NPC];
    tm_t        sdl_reg [NPC], sdl_next [NPC];

    logic [NUM_CHANNELS-1:0] run;
    logic [NUM_CHANNELS-1:0] run_res;

    function automatic logic reached(input tm_t now, input tm_t dl);
        tm_t d;
        d = now - dl;
        return ~d[TIME_BITS-1];
    endfunction

    function automatic tm_t later(input tm_t now, input logic [21:0] dt);
        return now + tm_t'(dt);
    endfunction

    assign run     = ~(mon ^ {NUM_CHANNELS{cfg.run_pol_high}});
    assign run_res = ~(mon_res ^ {NUM_CHANNELS{cfg.run_pol_high}});

    always_comb begin
        logic any_on, pc_run, on_v, cur;
        logic [CH_W-1:0] ch;
        now_next  = now_reg;
        cc_next   = cc_reg;
        ca_next   = ca_reg;
        op_next   = op_reg;
        fl_next   = fl_reg;
        gr_next   = gr_reg;
        offd_next = offd_reg;
        grd_next  = grd_reg;
        prs_next  = prs_reg;
        sw_next   = sw_reg;
        for (int p = 0; p < NPC; p++) begin
            req_next[p]  = req_reg[p];
            pend_next[p] = pend_reg[p];
            cdu_next[p]  = cdu_reg[p];
            sdl_next[p]  = sdl_reg[p];
        end
        ch     = channel;
        on_v   = turn_on;
        any_on = |(sw_reg | run[NPC-1:0]);
        pc_run = 1'b0;
        cur    = 1'b0;
        case (cmd_t'(cmd))
            CMD_TICK: begin
                now_next = now_reg + tm_t'(1);
                for (int p = 0; p < NPC; p++) begin
                    if (prs_reg[p]) begin
                        if (reached(now_next, pend_reg[p])) begin
                            prs_next[p] = 1'b0;
                            cdu_next[p] = later(now_next, {6'd0, cfg.press_cooldown_ms});
                        end
                    end else if (req_reg[p] != PRESS_NONE) begin
                        pend_next[p] = later(now_next, (req_reg[p] == PRESS_SHORT)
                            ? {6'd0, cfg.short_press_ms} : {6'd0, cfg.long_press_ms});
                        prs_next[p] = 1'b1;
                        req_next[p] = PRESS_NONE;
                    end
                end
                for (int p = 0; p < NPC; p++) begin
                    if (sw_next[p]) begin
                        if (run[COOL]) begin
                            if (req_next[p] == PRESS_NONE && !prs_next[p]
                                && reached(now_next, cdu_next[p]))
                                req_next[p] = PRESS_SHORT;
                            sw_next[p] = 1'b0;
                        end else if (reached(now_next, sdl_reg[p])) begin
                            sw_next[p] = 1'b0;
                            fl_next = 1'b1;
                        end
                    end
                end
                any_on = |(sw_next | run[NPC-1:0]);
                if (cc_next && ca_next && !any_on) begin
                    if (!op_reg) begin
                        op_next   = 1'b1;
                        offd_next = later(now_next, cfg.cool_off_delay_ms);
                    end else if (reached(now_next, offd_reg)) begin
                        cc_next = 1'b0;
                        ca_next = 1'b0;
                        op_next = 1'b0;
                    end
                end else begin
                    op_next = 1'b0;
                end
                pc_run = |run[NPC-1:0];
                if (pc_run && !run[COOL]) begin
                    if (!cc_next) begin
                        cc_next = 1'b1;
                        ca_next = 1'b1;
                    end
                    if (!gr_reg) begin
                        gr_next  = 1'b1;
                        grd_next = later(now_next, cfg.fault_grace_ms);
                    end else if (reached(now_next, grd_reg)) begin
                        for (int p = 0; p < NPC; p++) begin
                            sw_next[p] = 1'b0;
                            if (run[p])
                                req_next[p] = PRESS_LONG;
                        end
                        fl_next = 1'b1;
                        gr_next = 1'b0;
                    end
                end else begin
                    gr_next = 1'b0;
                end
            end
            CMD_SET, CMD_TOGGLE: begin
                if (ch < NUM_CHANNELS) begin
                    if (cmd_t'(cmd) == CMD_TOGGLE) begin
                        if (ch == COOL)
                            cur = cc_reg;
                        else
                            cur = sw_reg[ch] | run[ch];
                        on_v = ~cur;
                    end
                    if (ch == COOL) begin
                        if (on_v || !any_on) begin
                            cc_next = on_v;
                            ca_next = 1'b0;
                            op_next = 1'b0;
                        end
                    end else if (on_v) begin
                        if (!(sw_reg[ch] | run[ch])) begin
                            if (!cc_reg) begin
                                cc_next = 1'b1;
                                ca_next = 1'b1;
                            end
                            op_next = 1'b0;
                            if (run[COOL]) begin
                                if (req_reg[ch] == PRESS_NONE && !prs_reg[ch]
                                    && reached(now_reg, cdu_reg[ch]))
                                    req_next[ch] = PRESS_SHORT;
                                sw_next[ch] = 1'b0;
                            end else begin
                                sw_next[ch]  = 1'b1;
                                sdl_next[ch] = later(now_reg, cfg.spinup_timeout_ms);
                            end
                        end
                    end else begin
                        sw_next[ch] = 1'b0;
                        if (run[ch] && req_reg[ch] == PRESS_NONE && !prs_reg[ch]
                            && reached(now_reg, cdu_reg[ch]))
                            req_next[ch] = PRESS_SHORT;
                    end
                end
            end
            CMD_ACK: fl_next = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg  <= '0;
            cc_reg   <= 1'b0;
            ca_reg   <= 1'b0;
            op_reg   <= 1'b0;
            fl_reg   <= 1'b0;
            gr_reg   <= 1'b0;
            offd_reg <= '0;
            grd_reg  <= '0;
            prs_reg  <= '0;
            sw_reg   <= '0;
            for (int p = 0; p < NPC; p++) begin
                req_reg[p]  <= PRESS_NONE;
                pend_reg[p] <= '0;
                cdu_reg[p]  <= '0;
                sdl_reg[p]  <= '0;
            end
        end else if (en) begin
            now_reg  <= now_next;
            cc_reg   <= cc_next;
            ca_reg   <= ca_next;
            op_reg   <= op_next;
            fl_reg   <= fl_next;
            gr_reg   <= gr_next;
            offd_reg <= offd_next;
            grd_reg  <= grd_next;
            prs_reg  <= prs_next;
            sw_reg   <= sw_next;
            for (int p = 0; p < NPC; p++) begin
                req_reg[p]  <= req_next[p];
                pend_reg[p] <= pend_next[p];
                cdu_reg[p]  <= cdu_next[p];
                sdl_reg[p]  <= sdl_next[p];
            end
        end
    end

    // result fields from the state after the request; polarity live
    always_comb begin
        start_lines = {cc_reg == cfg.start_pol_high,
                       prs_reg ^ {NPC{~cfg.start_pol_high}}};
        channel_on     = {cc_reg, sw_reg | run_res[NPC-1:0]};
        cooling_fault  = fl_reg;
        cooling_locked = |(sw_reg | run_res[NPC-1:0]);
    end

    a_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        cooling_locked == |channel_on[NPC-1:0])
        else $error("lock flag disagrees with PC on bits");
    a_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        en && cmd_t'(cmd) == CMD_ACK |=> !fl_reg)
        else $error("fault not cleared by acknowledge");
    a_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        en && cmd_t'(cmd) != CMD_TICK |=> $stable(now_reg))
        else $error("time moved on a command");
    a_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (prs_reg & ~prs_next) != '0 && en |-> cmd_t'(cmd) == CMD_TICK)
        else $error("press released off a tick");

endmodule
`default_nettype wire

FILE: tb/sv/power_sequencer_cooling_interlock_tb.sv
// ----------------------------------------------------------------------------
// power_sequencer_cooling_interlock_tb
// Self-checking bench for the power sequencer with cooling interlock. Requests
// are driven with random gaps and results are drained with random stalls. A
// bench-side model of the sequencer predicts every result, which is then
// compared field by field. The run walks through several timing and polarity
// settings, written while the block is idle.
// ----------------------------------------------------------------------------
module power_sequencer_cooling_interlock_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psci_pkg::*;

    localparam int NPC  = 3;
    localparam int COOL = 3;

    typedef struct {
        cmd_t       cmd;
        logic [1:0] channel;
        logic       turn_on;
        logic [3:0] mon;
    } req_t;

    typedef struct {
        logic [3:0] start_lines;
        logic [3:0] channel_on;
        logic       cooling_fault;
        logic       cooling_locked;
    } seq_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CMD_W-1:0] s_cmd = '0;
    logic [CH_W-1:0] s_channel = '0;
    logic s_turn_on = 1'b0;
    logic [3:0] s_monitor_levels = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [3:0] m_start_lines;
    logic [3:0] m_channel_on;
    logic m_cooling_fault;
    logic m_cooling_locked;

    power_sequencer_cooling_interlock dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_channel(s_channel),
        .s_turn_on(s_turn_on), .s_monitor_levels(s_monitor_levels),
        .m_valid(m_valid), .m_ready(m_ready), .m_start_lines(m_start_lines),
        .m_channel_on(m_channel_on), .m_cooling_fault(m_cooling_fault),
        .m_cooling_locked(m_cooling_locked)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // sequencer model state
    cfg_t        cfg;
    bit [31:0]   now_ms, off_deadline, grace_deadline;
    bit          cool_cmd, cool_auto, off_pending, fault_latched, grace_running;
    press_t      press_req [NPC];
    bit          pressing [NPC];
    bit [31:0]   press_end [NPC];
    bit [31:0]   cooldown_until [NPC];
    bit          start_waiting [NPC];
    bit [31:0]   start_deadline [NPC];
    logic [3:0]  mon;

    req_t     pending_reqs[$];
    seq_out_t expected_outs[$];
    int       errors = 0;
    bit       burst = 0;
    int       gap_left = 0;
    int       stall_left = 0;

    function automatic bit [31:0] later(bit [31:0] dt);
        return now_ms + dt;
    endfunction

    function automatic bit hit(bit [31:0] deadline);
        bit [31:0] d;
        d = now_ms - deadline;
        return !d[31];
    endfunction

    function automatic bit running(int ch);
        return mon[ch] == cfg.run_pol_high;
    endfunction

    function automatic bit pc_active(int p);
        return start_waiting[p] || running(p);
    endfunction

    function automatic bit any_pc_on();
        for (int p = 0; p < NPC; p++) begin
            if (pc_active(p)) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic ask_press(int p);
        if (press_req[p] == PRESS_NONE && !pressing[p] && hit(cooldown_until[p]))
            press_req[p] = PRESS_SHORT;
    endtask

    task automatic set_supply(int ch, bit on);
        if (ch == COOL) begin
            if (!on && any_pc_on()) return;
            cool_cmd = on;
            cool_auto = 1'b0;
            off_pending = 1'b0;
        end else if (on) begin
            if (pc_active(ch)) return;
            if (!cool_cmd) begin
                cool_cmd = 1'b1;
                cool_auto = 1'b1;
            end
            off_pending = 1'b0;
            if (running(COOL)) begin
                ask_press(ch);
                start_waiting[ch] = 1'b0;
            end else begin
                start_waiting[ch] = 1'b1;
                start_deadline[ch] = later(32'(cfg.spinup_timeout_ms));
            end
        end else begin
            start_waiting[ch] = 1'b0;
            if (running(ch)) ask_press(ch);
        end
    endtask

    task automatic advance_ms();
        bit pc_run;
        pc_run = 1'b0;
        now_ms = now_ms + 1;
        for (int p = 0; p < NPC; p++) begin
            if (pressing[p]) begin
                if (hit(press_end[p])) begin
                    pressing[p] = 1'b0;
                    cooldown_until[p] = later(32'(cfg.press_cooldown_ms));
                end
            end else if (press_req[p] != PRESS_NONE) begin
                press_end[p] = later(press_req[p] == PRESS_SHORT ?
                                     32'(cfg.short_press_ms) : 32'(cfg.long_press_ms));
                pressing[p] = 1'b1;
                press_req[p] = PRESS_NONE;
            end
        end
        for (int p = 0; p < NPC; p++) begin
            if (!start_waiting[p]) continue;
            if (running(COOL)) begin
                ask_press(p);
                start_waiting[p] = 1'b0;
            end else if (hit(start_deadline[p])) begin
                start_waiting[p] = 1'b0;
                fault_latched = 1'b1;
            end
        end
        if (cool_cmd && cool_auto && !any_pc_on()) begin
            if (!off_pending) begin
                off_pending = 1'b1;
                off_deadline = later(32'(cfg.cool_off_delay_ms));
            end else if (hit(off_deadline)) begin
                cool_cmd = 1'b0;
                cool_auto = 1'b0;
                off_pending = 1'b0;
            end
        end else begin
            off_pending = 1'b0;
        end
        for (int p = 0; p < NPC; p++) begin
            if (running(p)) pc_run = 1'b1;
        end
        if (pc_run && !running(COOL)) begin
            if (!cool_cmd) begin
                cool_cmd = 1'b1;
                cool_auto = 1'b1;
            end
            if (!grace_running) begin
                grace_running = 1'b1;
                grace_deadline = later(32'(cfg.fault_grace_ms));
            end else if (hit(grace_deadline)) begin
                for (int p = 0; p < NPC; p++) begin
                    start_waiting[p] = 1'b0;
                    if (running(p)) press_req[p] = PRESS_LONG;
                end
                fault_latched = 1'b1;
                grace_running = 1'b0;
            end
        end else begin
            grace_running = 1'b0;
        end
    endtask

    task automatic apply_request(req_t r);
        seq_out_t o;
        mon = r.mon;
        case (r.cmd)
            CMD_TICK: advance_ms();
            CMD_SET: set_supply(r.channel, r.turn_on);
            CMD_TOGGLE: begin
                set_supply(r.channel, r.channel == COOL ? !cool_cmd : !pc_active(r.channel));
            end
            default: fault_latched = 1'b0;
        endcase
        o.start_lines = '0;
        o.channel_on = '0;
        for (int p = 0; p < NPC; p++) begin
            o.start_lines[p] = (pressing[p] == cfg.start_pol_high);
            o.channel_on[p] = pc_active(p);
        end
        o.start_lines[COOL] = (cool_cmd == cfg.start_pol_high);
        o.channel_on[COOL] = cool_cmd;
        o.cooling_fault = fault_latched;
        o.cooling_locked = any_pc_on();
        expected_outs.push_back(o);
    endtask

    // driver
    always @(posedge aclk) begin
        logic nv;
        req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nv = s_valid;
            if (s_valid && s_ready) begin
                r.cmd = cmd_t'(s_cmd);
                r.channel = s_channel;
                r.turn_on = s_turn_on;
                r.mon = s_monitor_levels;
                apply_request(r);
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    s_cmd <= r.cmd;
                    s_channel <= r.channel;
                    s_turn_on <= r.turn_on;
                    s_monitor_levels <= r.mon;
                    nv = 1'b1;
                    if ($urandom_range(0, 49) == 0) burst = !burst;
                    gap_left = burst ? 0 : $urandom_range(0, 14);
                end
            end
            s_valid <= nv;
        end
    end

    // monitor
    always @(posedge aclk) begin
        seq_out_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outs.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    e = expected_outs.pop_front();
                    if (m_start_lines !== e.start_lines) begin
                        $error("start_lines exp %h got %h", e.start_lines, m_start_lines);
                        errors++;
                    end
                    if (m_channel_on !== e.channel_on) begin
                        $error("channel_on exp %h got %h", e.channel_on, m_channel_on);
                        errors++;
                    end
                    if (m_cooling_fault !== e.cooling_fault) begin
                        $error("cooling_fault exp %b got %b", e.cooling_fault,
                               m_cooling_fault);
                        errors++;
                    end
                    if (m_cooling_locked !== e.cooling_locked) begin
                        $error("cooling_locked exp %b got %b", e.cooling_locked,
                               m_cooling_locked);
                        errors++;
                    end
                end
                stall_left = burst ? 0 : $urandom_range(0, 14);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [21:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_SHORT_PRESS: cfg.short_press_ms = val[15:0];
            REG_LONG_PRESS:  cfg.long_press_ms = val[15:0];
            REG_COOLDOWN:    cfg.press_cooldown_ms = val[15:0];
            REG_SPINUP:      cfg.spinup_timeout_ms = val;
            REG_COOL_OFF:    cfg.cool_off_delay_ms = val;
            REG_GRACE:       cfg.fault_grace_ms = val;
            REG_START_POL:   cfg.start_pol_high = val[0];
            default:         cfg.run_pol_high = val[0];
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [15:0] sp, logic [15:0] lp, logic [15:0] cd,
                             logic [21:0] su, logic [21:0] co, logic [21:0] gr,
                             logic spol, logic rpol);
        write_reg(REG_SHORT_PRESS, 22'(sp));
        write_reg(REG_LONG_PRESS, 22'(lp));
        write_reg(REG_COOLDOWN, 22'(cd));
        write_reg(REG_SPINUP, su);
        write_reg(REG_COOL_OFF, co);
        write_reg(REG_GRACE, gr);
        write_reg(REG_START_POL, 22'(spol));
        write_reg(REG_RUN_POL, 22'(rpol));
    endtask

    task automatic push_req(cmd_t c, int ch, bit on, logic [3:0] m);
        req_t r;
        r.cmd = c;
        r.channel = 2'(ch);
        r.turn_on = on;
        r.mon = m;
        pending_reqs.push_back(r);
    endtask

    logic [3:0] plant_mon = 4'hF;

    task automatic push_random(int n);
        int k;
        cmd_t c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) plant_mon[$urandom_range(0, 3)] ^= 1'b1;
            if ($urandom_range(0, 99) == 0) plant_mon = 4'($urandom);
            k = $urandom_range(0, 99);
            c = k < 78 ? CMD_TICK : k < 88 ? CMD_SET : k < 96 ? CMD_TOGGLE : CMD_ACK;
            push_req(c, $urandom_range(0, 3), $urandom_range(0, 1), plant_mon);
        end
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_outs.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        cfg.short_press_ms = RST_SHORT_PRESS;
        cfg.long_press_ms = RST_LONG_PRESS;
        cfg.press_cooldown_ms = RST_COOLDOWN;
        cfg.spinup_timeout_ms = RST_SPINUP;
        cfg.cool_off_delay_ms = RST_COOL_OFF;
        cfg.fault_grace_ms = RST_GRACE;
        cfg.start_pol_high = 1'b1;
        cfg.run_pol_high = 1'b0;
        now_ms = 0; off_deadline = 0; grace_deadline = 0;
        cool_cmd = 0; cool_auto = 0; off_pending = 0; fault_latched = 0; grace_running = 0;
        mon = '0;
        for (int p = 0; p < NPC; p++) begin
            press_req[p] = PRESS_NONE; pressing[p] = 0; press_end[p] = 0;
            cooldown_until[p] = 0; start_waiting[p] = 0; start_deadline[p] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults from reset
        push_random(150);
        drain();

        // short timings, directed requests first
        write_all(16'd3, 16'd8, 16'd5, 22'd12, 22'd20, 22'd15, 1'b1, 1'b0);
        push_req(CMD_TICK, 0, 0, 4'h0);
        push_req(CMD_TICK, 0, 0, 4'hF);
        push_req(CMD_SET, 0, 1, 4'hF);
        push_req(CMD_SET, 1, 1, 4'h7);
        push_req(CMD_TICK, 0, 0, 4'h5);
        push_req(CMD_SET, 3, 0, 4'h4);
        push_req(CMD_TOGGLE, 2, 0, 4'h3);
        push_req(CMD_TOGGLE, 3, 1, 4'hF);
        push_req(CMD_SET, 3, 1, 4'hF);
        push_req(CMD_SET, 0, 0, 4'h0);
        push_req(CMD_SET, 2, 0, 4'hB);
        push_req(CMD_TOGGLE, 1, 1, 4'h8);
        push_req(CMD_TOGGLE, 0, 0, 4'h6);
        for (int i = 0; i < 6; i++) push_req(CMD_TICK, 0, 0, 4'hE);
        push_req(CMD_ACK, 3, 1, 4'hF);
        push_req(CMD_ACK, 0, 0, 4'h0);
        drain();
        push_random(300);
        drain();

        // zero durations, inverted polarities
        write_all(16'd0, 16'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0, 1'b1);
        plant_mon = 4'h0;
        push_random(250);
        drain();

        // largest durations
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF,
                  1'b1, 1'b1);
        push_random(200);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_all(16'($urandom_range(0, 10)), 16'($urandom_range(0, 20)),
                      16'($urandom_range(0, 12)), 22'($urandom_range(0, 30)),
                      22'($urandom_range(0, 40)), 22'($urandom_range(0, 25)),
                      1'($urandom), 1'($urandom));
            push_random(220);
            drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/psci_pkg.sv
hw/rtl/psci_cfg_regs.sv
hw/rtl/psci_core.sv
hw/rtl/power_sequencer_cooling_interlock.sv
tb/sv/power_sequencer_cooling_interlock_tb.sv
